// ----- rtl/prt_pkg.sv -----
// Shared types for the periodic tick re-arm block: input word, result word,
// timer state. Used by prt_calc, the channel interfaces and the top level.
`default_nettype none

package prt_pkg;

  localparam int unsigned CountW    = 32;
  localparam int unsigned IntervalW = 31;

  localparam logic OpStart   = 1'b0;
  localparam logic OpCompare = 1'b1;

  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(1);

  // One input word
  typedef struct packed {
    logic              op;
    logic [CountW-1:0] count_at_entry;
    logic [CountW-1:0] count_at_recheck;
  } prt_item_t;

  // One result word
  typedef struct packed {
    logic [CountW-1:0] compare_value;
    logic              tick_taken;
    logic              resynced;
    logic [CountW-1:0] tick_total;
    logic [CountW-1:0] late_total;
    logic [CountW-1:0] spacing;
  } prt_result_t;

  // Timer state carried from word to word
  typedef struct packed {
    logic [CountW-1:0] next_deadline;
    logic [CountW-1:0] tick_counter;
    logic [CountW-1:0] late_counter;
    logic [CountW-1:0] last_spacing;
  } prt_state_t;

endpackage

`default_nettype wire

// ----- rtl/prt_if.sv -----
// Valid/ready channel interfaces for the input and result words.
// Depends on prt_pkg for the field widths.
`default_nettype none

interface prt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [prt_pkg::CountW-1:0] count_at_entry;
  logic [prt_pkg::CountW-1:0] count_at_recheck;

  modport source (output valid, output op, output count_at_entry,
                  output count_at_recheck, input ready);
  modport sink   (input valid, input op, input count_at_entry,
                  input count_at_recheck, output ready);
endinterface

interface prt_out_if;
  logic                       valid;
  logic                       ready;
  logic [prt_pkg::CountW-1:0] compare_value;
  logic                       tick_taken;
  logic                       resynced;
  logic [prt_pkg::CountW-1:0] tick_total;
  logic [prt_pkg::CountW-1:0] late_total;
  logic [prt_pkg::CountW-1:0] spacing;

  modport source (output valid, output compare_value, output tick_taken,
                  output resynced, output tick_total, output late_total,
                  output spacing, input ready);
  modport sink   (input valid, input compare_value, input tick_taken,
                  input resynced, input tick_total, input late_total,
                  input spacing, output ready);
endinterface

`default_nettype wire

// ----- rtl/prt_calc.sv -----
// Combinational update of the timer state for one word: start, early entry,
// tick with optional resync. Depends on prt_pkg.
`default_nettype none

module prt_calc (
  input  wire prt_pkg::prt_item_t               item,
  input  wire prt_pkg::prt_state_t              cur,
  input  wire logic [prt_pkg::IntervalW-1:0]    interval,
  output prt_pkg::prt_state_t                   nxt,
  output prt_pkg::prt_result_t                  res
);

  logic [prt_pkg::CountW-1:0] ival;
  logic [prt_pkg::CountW-1:0] since_dl;
  logic [prt_pkg::CountW-1:0] adv_dl;
  logic [prt_pkg::CountW-1:0] ahead;
  logic                       early;
  logic                       outside;
  logic                       tick;
  logic                       resync;

  assign ival     = {1'b0, interval};
  // entry minus deadline; its sign marks an early entry
  assign since_dl = item.count_at_entry - cur.next_deadline;
  assign early    = since_dl[prt_pkg::CountW-1];
  assign adv_dl   = cur.next_deadline + ival;
  // window check: deadline must sit 1..interval cycles ahead of the recheck
  assign ahead    = adv_dl - item.count_at_recheck;
  assign outside  = (ahead == '0) || ahead[prt_pkg::CountW-1] || (ahead > ival);

  assign tick   = (item.op == prt_pkg::OpCompare) && !early;
  assign resync = tick && outside;

  // next state
  always_comb begin
    nxt = cur;
    if (item.op == prt_pkg::OpStart) begin
      nxt.next_deadline = item.count_at_entry + ival;
      nxt.tick_counter  = '0;
      nxt.late_counter  = '0;
      nxt.last_spacing  = '0;
    end else if (tick) begin
      // entry - (deadline - interval)
      nxt.last_spacing  = since_dl + ival;
      nxt.tick_counter  = cur.tick_counter + prt_pkg::CountW'(1);
      if (outside) begin
        nxt.next_deadline = item.count_at_recheck + ival;
        nxt.late_counter  = cur.late_counter + prt_pkg::CountW'(1);
      end else begin
        nxt.next_deadline = adv_dl;
      end
    end
  end

  // result word mirrors the updated state
  assign res.compare_value = nxt.next_deadline;
  assign res.tick_taken    = tick;
  assign res.resynced      = resync;
  assign res.tick_total    = nxt.tick_counter;
  assign res.late_total    = nxt.late_counter;
  assign res.spacing       = nxt.last_spacing;

endmodule

`default_nettype wire

// ----- rtl/periodic_tick_rearm_core.sv -----
// Top level of the periodic tick re-arm block: input register, state update
// and result register. Depends on prt_pkg, prt_if and prt_calc.
//
// Usage:
//   in_ch  (sink)  : op (start / compare entry) with two counter reads.
//   out_ch (source): one result word per input word, in order: compare value
//                    to load, tick/resync flags and the running tallies.
//   cfg_we/cfg_wdata: writes tick_interval (31 bits); write only when idle.
// Path: an accepted word is held in the input register, then the state
//   update writes its result into the result register.
// Throughput: one word per cycle while out_ch.ready is high; the loop that
//   sets it is the prt_calc state update, whose result feeds the next word.
// Stalls: the result register holds while out_ch.ready is low; the input
//   register still takes one more word, then in_ch.ready drops.
// Reset (rst_n low, synchronous): both registers empty, all tallies and the
//   deadline zero, tick_interval one.
`default_nettype none

module periodic_tick_rearm_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  prt_in_if.sink                               in_ch,
  prt_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [prt_pkg::IntervalW-1:0]   cfg_wdata
);

  logic                              in_valid_r;
  prt_pkg::prt_item_t                in_word_r;
  logic                              out_valid_r;
  prt_pkg::prt_result_t              out_word_r;
  prt_pkg::prt_state_t               state_r;
  prt_pkg::prt_state_t               state_nxt;
  prt_pkg::prt_result_t              res_nxt;
  logic [prt_pkg::IntervalW-1:0]     interval_r;
  logic                              advance;
  logic                              in_take;

  // move a word from the input register into the result register
  assign advance = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  prt_calc u_calc (
    .item     (in_word_r),
    .cur      (state_r),
    .interval (interval_r),
    .nxt      (state_nxt),
    .res      (res_nxt)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      interval_r  <= prt_pkg::IntervalReset;
    end else begin
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r.op               <= in_ch.op;
      in_word_r.count_at_entry   <= in_ch.count_at_entry;
      in_word_r.count_at_recheck <= in_ch.count_at_recheck;
    end
    if (advance) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.compare_value = out_word_r.compare_value;
  assign out_ch.tick_taken    = out_word_r.tick_taken;
  assign out_ch.resynced      = out_word_r.resynced;
  assign out_ch.tick_total    = out_word_r.tick_total;
  assign out_ch.late_total    = out_word_r.late_total;
  assign out_ch.spacing       = out_word_r.spacing;

endmodule

`default_nettype wire

// ----- verif/periodic_tick_rearm_core_test.sv -----
// Testbench for periodic_tick_rearm_core: random and directed event words, with a
// scoreboard that tracks the deadline and the tallies. Depends on prt_pkg, prt_if
// and the RTL top level.
`timescale 1ns / 100ps

module periodic_tick_rearm_core_test;

  // Tracks deadline, tallies and interval; queues the expected re-arm words
  class deadline_tracker;
    logic [prt_pkg::CountW-1:0] interval = prt_pkg::CountW'(prt_pkg::IntervalReset);
    logic [prt_pkg::CountW-1:0] deadline = '0;
    logic [prt_pkg::CountW-1:0] ticks    = '0;
    logic [prt_pkg::CountW-1:0] lates    = '0;
    logic [prt_pkg::CountW-1:0] spacing  = '0;
    prt_pkg::prt_result_t       expected_rearms[$];
    int unsigned                mismatches = 0;

    function void set_interval(logic [prt_pkg::IntervalW-1:0] v);
      interval = {1'b0, v};
    endfunction

    function int unsigned pending();
      return expected_rearms.size();
    endfunction

    // Advance the timer state for one accepted event word
    function void note_event(prt_pkg::prt_item_t w);
      prt_pkg::prt_result_t       r;
      logic [prt_pkg::CountW-1:0] lag;
      logic [prt_pkg::CountW-1:0] ahead;
      r.tick_taken = 1'b0;
      r.resynced   = 1'b0;
      lag = w.count_at_entry - deadline;
      if (w.op == prt_pkg::OpStart) begin
        ticks    = '0;
        lates    = '0;
        spacing  = '0;
        deadline = w.count_at_entry + interval;
      end else if (!lag[prt_pkg::CountW-1]) begin
        // tick: spacing measured from the previous nominal deadline
        spacing  = w.count_at_entry - (deadline - interval);
        deadline = deadline + interval;
        ahead    = deadline - w.count_at_recheck;
        // new deadline must lie 1..interval cycles past the recheck read
        if (ahead == '0 || ahead[prt_pkg::CountW-1] || ahead > interval) begin
          deadline   = w.count_at_recheck + interval;
          lates      = lates + prt_pkg::CountW'(1);
          r.resynced = 1'b1;
        end
        ticks        = ticks + prt_pkg::CountW'(1);
        r.tick_taken = 1'b1;
      end
      // early entry falls through with state unchanged
      r.compare_value = deadline;
      r.tick_total    = ticks;
      r.late_total    = lates;
      r.spacing       = spacing;
      expected_rearms.push_back(r);
    endfunction

    function void field_ok(string name, logic [prt_pkg::CountW-1:0] want,
                           logic [prt_pkg::CountW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_rearm(prt_pkg::prt_result_t got);
      prt_pkg::prt_result_t want;
      if (expected_rearms.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual compare_value %h",
                 $time, got.compare_value);
        mismatches++;
        return;
      end
      want = expected_rearms.pop_front();
      field_ok("compare_value", want.compare_value, got.compare_value);
      field_ok("tick_taken", prt_pkg::CountW'(want.tick_taken),
               prt_pkg::CountW'(got.tick_taken));
      field_ok("resynced", prt_pkg::CountW'(want.resynced),
               prt_pkg::CountW'(got.resynced));
      field_ok("tick_total", want.tick_total, got.tick_total);
      field_ok("late_total", want.late_total, got.late_total);
      field_ok("spacing", want.spacing, got.spacing);
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [prt_pkg::IntervalW-1:0] cfg_wdata;
  bit                            steady = 1'b0;  // no idling on either side while set

  prt_in_if  in_ch ();
  prt_out_if out_ch ();

  deadline_tracker tracker = new;

  periodic_tick_rearm_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic prt_pkg::prt_item_t compose_word(logic op,
                                                      logic [prt_pkg::CountW-1:0] entry,
                                                      logic [prt_pkg::CountW-1:0] recheck);
    prt_pkg::prt_item_t w;
    w.op               = op;
    w.count_at_entry   = entry;
    w.count_at_recheck = recheck;
    return w;
  endfunction

  // Mostly compare words placed around the current deadline, some starts and noise
  function automatic prt_pkg::prt_item_t next_event_word();
    prt_pkg::prt_item_t         w;
    logic [prt_pkg::CountW-1:0] dl;
    logic [prt_pkg::CountW-1:0] iv;
    logic [prt_pkg::CountW-1:0] lag;
    int unsigned                pick;
    int unsigned                rpick;
    dl    = tracker.deadline;
    iv    = tracker.interval;
    pick  = $urandom_range(0, 99);
    rpick = $urandom_range(0, 9);
    w = compose_word(prt_pkg::OpCompare, dl, $urandom);
    if (pick < 4) begin
      w.op             = prt_pkg::OpStart;
      w.count_at_entry = $urandom;
    end else if (pick < 10) begin
      w.op             = 1'($urandom_range(0, 1));
      w.count_at_entry = $urandom;
    end else if (pick < 20) begin
      // early entry, near or far before the deadline
      w.count_at_entry = dl - ((pick < 17) ? $urandom_range(1, 8)
                                           : $urandom_range(1, 32'h8000_0000));
    end else begin
      if (pick < 55)      lag = $urandom_range(0, 3);
      else if (pick < 85) lag = (iv > 1) ? $urandom_range(0, iv - 1) : '0;
      else                lag = $urandom_range(0, 32'h7FFF_FFFF);
      w.count_at_entry = dl + lag;
      if (rpick < 6)      w.count_at_recheck = w.count_at_entry + $urandom_range(0, 3);
      else if (rpick < 8) w.count_at_recheck = w.count_at_entry + $urandom_range(0, iv + 8);
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_event(prt_pkg::prt_item_t w);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.op               <= w.op;
    in_ch.count_at_entry   <= w.count_at_entry;
    in_ch.count_at_recheck <= w.count_at_recheck;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_event(w);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Interval writes only once the block has emptied
  task automatic program_interval(logic [prt_pkg::IntervalW-1:0] v);
    stop_sending();
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_interval(v);
    cfg_we <= 1'b0;
  endtask

  // Result side: random back-pressure, check every accepted word
  initial begin : receive
    int unsigned          hold;
    prt_pkg::prt_result_t got;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.compare_value = out_ch.compare_value;
        got.tick_taken    = out_ch.tick_taken;
        got.resynced      = out_ch.resynced;
        got.tick_total    = out_ch.tick_total;
        got.late_total    = out_ch.late_total;
        got.spacing       = out_ch.spacing;
        tracker.check_rearm(got);
      end
      if (hold == 0 && $urandom_range(0, 99) < 25) hold = idle_len();
      out_ch.ready <= (hold == 0);
      if (hold != 0) hold--;
    end
  end

  initial begin : stimulus
    logic [prt_pkg::IntervalW-1:0] phase_iv[8];
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.op               <= prt_pkg::OpStart;
    in_ch.count_at_entry   <= '0;
    in_ch.count_at_recheck <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // compares on the reset state and after a start, interval still at its reset value
    send_event(compose_word(prt_pkg::OpCompare, 32'd0, 32'd0));
    send_event(compose_word(prt_pkg::OpCompare, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_event(compose_word(prt_pkg::OpStart, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_event(compose_word(prt_pkg::OpCompare, 32'd0, 32'd0));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline,
                            tracker.deadline + 32'd7));

    // widest interval: extreme lags both ways
    program_interval(31'h7FFF_FFFF);
    send_event(compose_word(prt_pkg::OpStart, 32'd0, 32'hFFFF_FFFF));
    send_event(compose_word(prt_pkg::OpCompare, 32'd0, 32'd0));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline - 32'h8000_0000, 32'd0));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline, tracker.deadline));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline + 32'h7FFF_FFFF,
                            tracker.deadline + 32'h7FFF_FFFF));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline,
                            tracker.deadline + 32'h7FFF_FFFE));

    // zero interval: the window is empty, every tick resyncs
    program_interval(31'd0);
    send_event(compose_word(prt_pkg::OpStart, 32'h1234_5678, 32'd0));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline, tracker.deadline));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline + 32'd9,
                            tracker.deadline + 32'd9));

    // small interval: window edges, recheck behind the window, one cycle early
    program_interval(31'd5);
    send_event(compose_word(prt_pkg::OpStart, 32'd100, 32'd0));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline, tracker.deadline));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline + 32'd2,
                            tracker.deadline - 32'd1));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline - 32'd1, 32'd0));
    send_event(compose_word(prt_pkg::OpCompare, tracker.deadline + 32'd4,
                            tracker.deadline + 32'd4));

    // random phases over a spread of intervals
    phase_iv[0] = 31'd1;
    phase_iv[1] = 31'h7FFF_FFFF;
    phase_iv[2] = 31'd0;
    phase_iv[3] = 31'($urandom_range(2, 16));
    phase_iv[4] = 31'($urandom_range(17, 5000));
    phase_iv[5] = 31'($urandom);
    phase_iv[6] = 31'd3;
    phase_iv[7] = 31'($urandom_range(2, 64));
    foreach (phase_iv[p]) begin
      program_interval(phase_iv[p]);
      send_event(compose_word(prt_pkg::OpStart, $urandom, $urandom));
      for (int i = 0; i < 225; i++) begin
        if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        send_event(next_event_word());
      end
      steady = 1'b0;
    end

    stop_sending();
    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/prt_pkg.sv
rtl/prt_if.sv
rtl/prt_calc.sv
rtl/periodic_tick_rearm_core.sv
verif/periodic_tick_rearm_core_test.sv
